// ----- src/flex_angle_kalman_smoother_defines.svh -----
// Assertion macros for the checker file of the bend angle smoother.
`ifndef FLEX_ANGLE_KALMAN_SMOOTHER_DEFINES_SVH
`define FLEX_ANGLE_KALMAN_SMOOTHER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is applied.
`define FKS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that must hold at every edge, reset included.
`define FKS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fks_pkg.sv -----
// Package with the constants, codes and types of the bend angle smoother.
`timescale 1ns / 1ps

package fks_pkg;

    // Block dimensions
    localparam int CHANNELS  = 5;
    localparam int WINDOW    = 5;

    // Field and datapath widths
    localparam int FINGER_W  = 3;
    localparam int RAW_W     = 16;
    localparam int ANGLE_W   = 15;
    localparam int THR_W     = 15;
    localparam int QN_W      = 16;
    localparam int COV_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 18;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int RAM_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int SUM_W     = ANGLE_W + CNT_W;
    localparam int DEN_W     = COV_W + 1;
    localparam int QUO_W     = 17;
    localparam int STEP_W    = 5;
    localparam int MUL_W     = COV_W + QUO_W;

    // Divider step counts for the gain and the window mean
    localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(QUO_W);
    localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(ANGLE_W);

    // Arithmetic constants
    localparam logic [QUO_W-1:0] K_ONE      = 17'h10000;
    localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(32768);
    localparam logic [COV_W-1:0] COV_MAX    = '1;
    localparam logic [COV_W-1:0] COV_RESET  = 18'd65536;

    // Register reset values
    localparam logic [THR_W-1:0]   THR_RESET  = 15'd7680;
    localparam logic [QN_W-1:0]    QN_RESET   = 16'd6554;
    localparam logic [COV_W-1:0]   RN_RESET   = 18'd65536;
    localparam logic [ANGLE_W-1:0] AMAX_RESET = 15'd23040;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTLIER_THRESHOLD  = 3'd0,
        REG_PROCESS_NOISE      = 3'd1,
        REG_MEASUREMENT_NOISE  = 3'd2,
        REG_INITIAL_COVARIANCE = 3'd3,
        REG_ANGLE_MAX          = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_CHECK,
        S_KSTART,
        S_KWAIT,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_UPDATE,
        S_SUM,
        S_MSTART,
        S_MWAIT,
        S_OUT
    } fsm_state_t;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DEN_W-1:0]  rem_init;
        logic [QUO_W-1:0]  bits;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    // Answer of the shared divider
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- src/fks_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module fks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fks_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fks_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  fks_pkg::div_req_t req,
    output fks_pkg::div_rsp_t rsp
);

    import fks_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  bits_reg, bits_next;
    logic [QUO_W-1:0]  quot_reg, quot_next;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    trial;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    // One shift, compare and subtract per cycle
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        bits_next  = bits_reg;
        quot_next  = quot_reg;
        shifted    = {rem_reg, bits_reg[QUO_W-1]};
        trial      = shifted - {1'b0, den_reg};

        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = req.steps;
            rem_next   = req.rem_init;
            bits_next  = req.bits;
            den_next   = req.den;
            quot_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[QUO_W-2:0], 1'b0};
            end
            bits_next  = {bits_reg[QUO_W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- src/flex_angle_kalman_smoother.sv -----
// Top level of the per-finger bend angle Kalman smoother.
//
//  Channel   Direction  Payload (low bit first)                      Width
//  s_axis    in         tuser: finger; tdata: sample angle           3 / 16
//  m_axis    out        tuser: finger_out, outlier_seen;             4 / 32
//                       tdata: window mean, kalman_estimate, pad
//  cfg       in         cfg_we, cfg_index, cfg_data                  1/3/18
//
// One sample occupies the block from the request to the result register,
// longer the more window entries are filled. The shared divider does
// most of the work: 17 steps for the gain and 15 for the window mean;
// the window sum reads one entry a cycle. When P + R is zero the gain
// division is skipped. The block takes no new sample until the result is
// in the output register; a stalled output holds the block in its last
// step. Reset is asynchronous and active low and needs no clearing pass.
`timescale 1ns / 1ps

module flex_angle_kalman_smoother (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // sample angle
    input  logic [2:0]                    s_axis_tuser,   // finger
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // window mean, kalman_estimate
    output logic [3:0]                    m_axis_tuser,   // finger_out, outlier_seen
    input  logic                          cfg_we,
    input  logic [fks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fks_pkg::CFG_W-1:0]     cfg_data
);

    import fks_pkg::*;

    // Configuration registers
    logic [THR_W-1:0]   thr_reg;
    logic [QN_W-1:0]    qn_reg;
    logic [COV_W-1:0]   rn_reg;
    logic [ANGLE_W-1:0] amax_reg;

    // Per-finger state
    logic [ANGLE_W-1:0] est_reg  [CHANNELS];
    logic [ANGLE_W-1:0] est_next [CHANNELS];
    logic [COV_W-1:0]   cov_reg  [CHANNELS];
    logic [COV_W-1:0]   cov_next [CHANNELS];
    logic [SLOT_W-1:0]  slot_reg [CHANNELS];
    logic [SLOT_W-1:0]  slot_next[CHANNELS];
    logic [CNT_W-1:0]   fill_reg [CHANNELS];
    logic [CNT_W-1:0]   fill_next[CHANNELS];
    logic [ANGLE_W-1:0] last_reg [CHANNELS];
    logic [ANGLE_W-1:0] last_next[CHANNELS];
    logic               seen_reg, seen_next;

    // Sequencer and working registers
    fsm_state_t         state_reg, state_next;
    logic [FINGER_W-1:0] finger_reg, finger_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [ANGLE_W-1:0] z_reg, z_next;
    logic               flag_reg, flag_next;
    logic [COV_W-1:0]   p_reg, p_next;
    logic [QUO_W-1:0]   k_reg, k_next;
    logic [MUL_W-1:0]   acc_reg, acc_next;
    logic [ANGLE_W-1:0] xnew_reg, xnew_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ANGLE_W-1:0] mean_reg, mean_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [FINGER_W-1:0] out_finger_reg, out_finger_next;
    logic [ANGLE_W-1:0] out_smooth_reg, out_smooth_next;
    logic [ANGLE_W-1:0] out_est_reg, out_est_next;
    logic               out_flag_reg, out_flag_next;

    // Combinational helpers
    logic [CH_W-1:0]    fidx;
    logic [ADDR_W-1:0]  base_addr;
    logic [ANGLE_W-1:0] diff;
    logic [DEN_W-1:0]   psum;
    logic [DEN_W-1:0]   gain_den;
    logic [SUM_W-1:0]   mean_num;
    logic [QUO_W-1:0]   omk;
    logic [COV_W-1:0]   mul_a;
    logic [QUO_W-1:0]   mul_b;
    logic [MUL_W-1:0]   mul_p;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ANGLE_W-1:0] ram_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign fidx      = finger_reg[CH_W-1:0];
    assign base_addr = ADDR_W'(fidx) * ADDR_W'(WINDOW);
    assign omk       = K_ONE - k_reg;
    assign mul_p     = MUL_W'(mul_a) * MUL_W'(mul_b);

    // Window store, one row of WINDOW entries per finger
    fks_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (xnew_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared divider for the gain and the window mean
    fks_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes; the initial covariance only matters at reset,
    // where it always holds its reset value, so its writes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            qn_reg   <= QN_RESET;
            rn_reg   <= RN_RESET;
            amax_reg <= AMAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OUTLIER_THRESHOLD:  thr_reg  <= cfg_data[THR_W-1:0];
                REG_PROCESS_NOISE:      qn_reg   <= cfg_data[QN_W-1:0];
                REG_MEASUREMENT_NOISE:  rn_reg   <= cfg_data[COV_W-1:0];
                REG_INITIAL_COVARIANCE: ;
                REG_ANGLE_MAX:          amax_reg <= cfg_data[ANGLE_W-1:0];
                default:                ;
            endcase
        end
    end

    // State register and per-finger state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            issue_reg     <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                est_reg[c]  <= '0;
                cov_reg[c]  <= COV_RESET;
                slot_reg[c] <= '0;
                fill_reg[c] <= '0;
                last_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issue_reg     <= issue_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            last_reg      <= last_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        finger_reg     <= finger_next;
        raw_reg        <= raw_next;
        z_reg          <= z_next;
        flag_reg       <= flag_next;
        p_reg          <= p_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        xnew_reg       <= xnew_next;
        sum_reg        <= sum_next;
        mean_reg       <= mean_next;
        out_finger_reg <= out_finger_next;
        out_smooth_reg <= out_smooth_next;
        out_est_reg    <= out_est_next;
        out_flag_reg   <= out_flag_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        est_next        = est_reg;
        cov_next        = cov_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        last_next       = last_reg;
        finger_next     = finger_reg;
        raw_next        = raw_reg;
        z_next          = z_reg;
        flag_next       = flag_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        xnew_next       = xnew_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        out_finger_next = out_finger_reg;
        out_smooth_next = out_smooth_reg;
        out_est_next    = out_est_reg;
        out_flag_next   = out_flag_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        s_axis_tready   = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        ram_we          = 1'b0;
        ram_waddr       = base_addr + ADDR_W'(slot_reg[fidx]);
        ram_raddr       = base_addr + ADDR_W'(issue_reg[SLOT_W-1:0]);
        div_req         = '0;

        diff     = (z_reg > last_reg[fidx]) ? (z_reg - last_reg[fidx])
                                            : (last_reg[fidx] - z_reg);
        psum     = {1'b0, cov_reg[fidx]} + DEN_W'(qn_reg);
        gain_den = {1'b0, p_reg} + {1'b0, rn_reg};
        mean_num = sum_reg + SUM_W'(fill_reg[fidx] >> 1);

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (int'(s_axis_tuser) < CHANNELS))
                begin
                    finger_next = s_axis_tuser;
                    raw_next    = s_axis_tdata;
                    state_next  = S_CLAMP;
                end
            end

            // Negative samples go to zero, large ones to the upper bound.
            S_CLAMP:
            begin
                if (raw_reg[RAW_W-1])
                begin
                    z_next = '0;
                end
                else if (raw_reg[ANGLE_W-1:0] > amax_reg)
                begin
                    z_next = amax_reg;
                end
                else
                begin
                    z_next = raw_reg[ANGLE_W-1:0];
                end
                state_next = S_CHECK;
            end

            // Outlier replacement and predicted covariance.
            S_CHECK:
            begin
                flag_next = 1'b0;
                if (seen_reg && (diff > thr_reg))
                begin
                    z_next    = last_reg[fidx];
                    flag_next = 1'b1;
                end
                seen_next  = 1'b1;
                p_next     = psum[DEN_W-1] ? COV_MAX : psum[COV_W-1:0];
                state_next = S_KSTART;
            end

            // Gain K = P / (P + R) in Q1.16; the divider gets P >> 1 as its
            // starting remainder, which is always below the divisor.
            S_KSTART:
            begin
                if (gain_den == '0)
                begin
                    k_next     = '0;
                    state_next = S_MUL0;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = GAIN_STEPS;
                    div_req.rem_init = DEN_W'(p_reg[COV_W-1:1]);
                    div_req.bits     = {p_reg[0], {(QUO_W-1){1'b0}}};
                    div_req.den      = gain_den;
                    state_next       = S_KWAIT;
                end
            end

            S_KWAIT:
            begin
                if (div_rsp.done)
                begin
                    k_next     = div_rsp.quot;
                    state_next = S_MUL0;
                end
            end

            // Estimate: x * (1 - K) + z * K, rounded.
            S_MUL0:
            begin
                mul_a      = COV_W'(est_reg[fidx]);
                mul_b      = omk;
                acc_next   = mul_p;
                state_next = S_MUL1;
            end

            S_MUL1:
            begin
                mul_a      = COV_W'(z_reg);
                mul_b      = k_reg;
                acc_next   = acc_reg + mul_p + ROUND_HALF;
                state_next = S_MUL2;
            end

            // Covariance: P * (1 - K), rounded.
            S_MUL2:
            begin
                xnew_next  = acc_reg[16 +: ANGLE_W];
                mul_a      = p_reg;
                mul_b      = omk;
                acc_next   = mul_p + ROUND_HALF;
                state_next = S_UPDATE;
            end

            // Commit the update and push the estimate into the ring.
            S_UPDATE:
            begin
                est_next[fidx] = xnew_reg;
                cov_next[fidx] = acc_reg[16 +: COV_W];
                ram_we         = 1'b1;
                if (slot_reg[fidx] == SLOT_W'(WINDOW - 1))
                begin
                    slot_next[fidx] = '0;
                end
                else
                begin
                    slot_next[fidx] = slot_reg[fidx] + 1'b1;
                end
                if (fill_reg[fidx] < CNT_W'(WINDOW))
                begin
                    fill_next[fidx] = fill_reg[fidx] + 1'b1;
                end
                issue_next = '0;
                pend_next  = 1'b0;
                sum_next   = '0;
                state_next = S_SUM;
            end

            // Sum the filled entries, one read a cycle.
            S_SUM:
            begin
                if (issue_reg < fill_reg[fidx])
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                end
                if ((issue_reg == fill_reg[fidx]) && !pend_reg)
                begin
                    state_next = S_MSTART;
                end
            end

            // Mean with round half up; the quotient fits the angle width.
            S_MSTART:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = MEAN_STEPS;
                div_req.rem_init = DEN_W'(mean_num[SUM_W-1:ANGLE_W]);
                div_req.bits     = {mean_num[ANGLE_W-1:0], {(QUO_W-ANGLE_W){1'b0}}};
                div_req.den      = DEN_W'(fill_reg[fidx]);
                state_next       = S_MWAIT;
            end

            S_MWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot[ANGLE_W-1:0] > amax_reg)
                    begin
                        mean_next = amax_reg;
                    end
                    else
                    begin
                        mean_next = div_rsp.quot[ANGLE_W-1:0];
                    end
                    state_next = S_OUT;
                end
            end

            // Load the result once the output register is free.
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_finger_next = finger_reg;
                    out_smooth_next = mean_reg;
                    out_est_next    = (est_reg[fidx] > amax_reg) ? amax_reg
                                                                 : est_reg[fidx];
                    out_flag_next   = flag_reg;
                    last_next[fidx] = mean_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_est_reg, out_smooth_reg};
    assign m_axis_tuser  = {out_flag_reg, out_finger_reg};

endmodule

// ----- src/fks_checker.sv -----
// Port checker for the bend angle smoother, bound to the top level.
`timescale 1ns / 1ps
`include "flex_angle_kalman_smoother_defines.svh"

module fks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    import fks_pkg::*;

    // A result that is not taken stays offered.
    `FKS_ASSERT_RST(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `FKS_ASSERT_RST(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // A sample for a real finger keeps the block busy on the next cycle.
    `FKS_ASSERT_RST(a_busy_after_take, clk, rst_n, s_axis_tvalid && s_axis_tready && (int'(s_axis_tuser) < CHANNELS) |=> !s_axis_tready, "new request taken while working")

    // Results only ever name an existing finger.
    `FKS_ASSERT_ALWAYS(a_finger_range, clk, m_axis_tvalid |-> (int'(m_axis_tuser[2:0]) < CHANNELS), "result for a finger that does not exist")

endmodule

bind flex_angle_kalman_smoother fks_checker u_fks_checker (.*);
